FILE: hw/rtl/atfb_pkg.sv
// Package for the API transmit frame builder: item structs, configuration
// register indexes, frame byte positions and the header byte selector.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package atfb_pkg;

    // One input item: a payload byte and the frame length read on a frame's first byte.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [8:0] payload_length;
    } in_item_t;

    // One result item: a byte of the serialized frame and its markers.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
    } out_item_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [7:0]  start_delimiter;
        logic [7:0]  frame_type_code;
        logic [7:0]  frame_ident;
        logic [63:0] dest_address;
        logic [15:0] network_address;
        logic [7:0]  broadcast_radius;
        logic [7:0]  option_bits;
    } cfg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DELIM = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TYPE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_IDENT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_ADDR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NET_ADDR    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPTIONS     = 3'd6;

    // Register values after reset.
    localparam logic [7:0]  RST_START_DELIM = 8'h7E;
    localparam logic [7:0]  RST_FRAME_TYPE  = 8'h10;
    localparam logic [7:0]  RST_FRAME_IDENT = 8'h01;
    localparam logic [63:0] RST_DEST_ADDR   = 64'h0000_0000_0000_FFFF;
    localparam logic [15:0] RST_NET_ADDR    = 16'hFFFE;
    localparam logic [7:0]  RST_RADIUS      = 8'h00;
    localparam logic [7:0]  RST_OPTIONS     = 8'h00;

    // Bytes in the length field beyond the payload itself.
    localparam logic [16:0] HEADER_EXTRA = 17'd14;

    // Byte positions within the bytes one item can cause.
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_DELIM     = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE      = 5'd3;
    localparam logic [POS_W-1:0] POS_IDENT     = 5'd4;
    localparam logic [POS_W-1:0] POS_DEST_MSB  = 5'd5;
    localparam logic [POS_W-1:0] POS_DEST_LSB  = 5'd12;
    localparam logic [POS_W-1:0] POS_NET_HI    = 5'd13;
    localparam logic [POS_W-1:0] POS_NET_LO    = 5'd14;
    localparam logic [POS_W-1:0] POS_RADIUS    = 5'd15;
    localparam logic [POS_W-1:0] POS_OPTIONS   = 5'd16;
    localparam logic [POS_W-1:0] POS_DATA      = 5'd17;
    localparam logic [POS_W-1:0] POS_CHECKSUM  = 5'd18;

    // Header byte at a given position. Destination address bytes go out MSB first.
    function automatic logic [7:0] header_byte(input cfg_t cfg, input logic [15:0] total,
                                               input logic [POS_W-1:0] pos);
        logic [2:0] dest_sel;
        dest_sel = 3'(POS_DEST_LSB - pos);
        case (pos)
            POS_DELIM:   header_byte = cfg.start_delimiter;
            POS_LEN_HI:  header_byte = total[15:8];
            POS_LEN_LO:  header_byte = total[7:0];
            POS_TYPE:    header_byte = cfg.frame_type_code;
            POS_IDENT:   header_byte = cfg.frame_ident;
            POS_NET_HI:  header_byte = cfg.network_address[15:8];
            POS_NET_LO:  header_byte = cfg.network_address[7:0];
            POS_RADIUS:  header_byte = cfg.broadcast_radius;
            POS_OPTIONS: header_byte = cfg.option_bits;
            default: begin
                if (pos >= POS_DEST_MSB && pos <= POS_DEST_LSB) begin
                    header_byte = cfg.dest_address[dest_sel*8 +: 8];
                end else begin
                    header_byte = 8'h00;
                end
            end
        endcase
    endfunction

endpackage

FILE: hw/rtl/api_transmit_frame_builder.sv
// Top level of the API transmit frame builder: item register, byte sequencer,
// checksum accumulator and result register. Depends on atfb_pkg and atfb_cfg_regs.
`timescale 1ns / 1ps

// Usage:
// Payload bytes enter on the s_ channel, one item per byte. When no frame is
// open, the item's payload_length (1 to MAX_PAYLOAD; zero counts as one, larger
// values saturate) opens a frame and the item causes 17 header bytes, the
// payload byte, and a checksum if the frame holds one byte. Later items cause
// the payload byte alone, and the closing item adds the checksum. Each result
// on m_ carries run_last on the last byte of its item and frame_done on the
// checksum.
// Throughput: while m_ready is high, one result byte per cycle, and a frame
// body streams at one item per cycle. A frame's first item holds the sequencer
// through its header and payload bytes, and the checksum if it closes the
// frame; a closing item holds it through its payload byte and checksum.
// An item waits in the item register; its bytes leave via the result register.
// Stalls: while m_ready is low the result register holds and the sequencer
// waits; one further item can be accepted only into an empty item register.
// Reset (aresetn low, synchronous) empties both registers, closes any open
// frame and restores the header registers. The user writes registers on the
// always-ready cfg_ channel only while the block is idle; the block won't check.
module api_transmit_frame_builder #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  atfb_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output atfb_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [atfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [atfb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import atfb_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    cfg_t cfg;

    // Frame tracking at the input.
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic             s_accept;
    logic             frame_open;
    logic [16:0]      len_ext, len_sat;
    logic [LEN_W-1:0] len_first;

    // Item register.
    logic             item_valid_reg, item_valid_next;
    logic [7:0]       item_data_reg;
    logic             item_close_reg;
    logic [15:0]      item_total_reg;
    logic             item_close_next;

    // Sequencer and checksum.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic             emit, last_pos, item_done, summed;
    logic [7:0]       cur_byte;

    // Result register.
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg;

    atfb_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Length of a new frame: zero counts as one, larger values saturate.
    always_comb begin
        len_ext = 17'(s_data.payload_length);
        if (len_ext == 17'd0) begin
            len_sat = 17'd1;
        end else if (len_ext > 17'(MAX_PAYLOAD)) begin
            len_sat = 17'(MAX_PAYLOAD);
        end else begin
            len_sat = len_ext;
        end
        len_first = LEN_W'(len_sat);
    end

    assign frame_open = (bytes_left_reg != '0);
    assign s_accept   = s_valid && s_ready;

    // Count down payload bytes as items are accepted.
    always_comb begin
        bytes_left_next = bytes_left_reg;
        item_close_next = 1'b0;
        if (frame_open) begin
            item_close_next = (bytes_left_reg == LEN_W'(1));
        end else begin
            item_close_next = (len_first == LEN_W'(1));
        end
        if (s_accept) begin
            bytes_left_next = frame_open ? bytes_left_reg - LEN_W'(1)
                                         : len_first - LEN_W'(1);
        end
    end

    // Sequencer emits one byte per cycle while the result register can take it.
    assign emit      = item_valid_reg && (!m_valid_reg || m_ready);
    assign last_pos  = item_close_reg ? (pos_reg == POS_CHECKSUM) : (pos_reg == POS_DATA);
    assign item_done = emit && last_pos;
    assign s_ready   = !item_valid_reg || item_done;
    assign summed    = (pos_reg >= POS_TYPE) && (pos_reg <= POS_DATA);

    always_comb begin
        if (pos_reg == POS_DATA) begin
            cur_byte = item_data_reg;
        end else if (pos_reg == POS_CHECKSUM) begin
            cur_byte = ~sum_reg;
        end else begin
            cur_byte = header_byte(cfg, item_total_reg, pos_reg);
        end
    end

    // Position, item occupancy and checksum updates.
    always_comb begin
        pos_next        = pos_reg;
        item_valid_next = item_valid_reg;
        sum_next        = sum_reg;
        if (emit) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_DELIM || pos_reg == POS_CHECKSUM) begin
                sum_next = 8'h00;
            end else if (summed) begin
                sum_next = sum_reg + cur_byte;
            end
        end
        if (item_done) begin
            item_valid_next = 1'b0;
        end
        if (s_accept) begin
            item_valid_next = 1'b1;
            pos_next        = frame_open ? POS_DATA : POS_DELIM;
        end
    end

    // Result register handshake.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            item_valid_reg <= 1'b0;
            pos_reg        <= POS_DELIM;
            sum_reg        <= 8'h00;
            m_valid_reg    <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            item_valid_reg <= item_valid_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_data_reg  <= s_data.payload_byte;
            item_close_reg <= item_close_next;
            item_total_reg <= 16'(len_sat + HEADER_EXTRA);
        end
        if (emit) begin
            m_data_reg.out_byte   <= cur_byte;
            m_data_reg.run_last   <= last_pos;
            m_data_reg.frame_done <= (pos_reg == POS_CHECKSUM);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/atfb_cfg_regs.sv
// Configuration register file of the API transmit frame builder.
// Depends on atfb_pkg for the register struct, indexes and reset values.
`timescale 1ns / 1ps

module atfb_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [atfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [atfb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output atfb_pkg::cfg_t                       cfg
);
    import atfb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; an index beyond the list changes nothing.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Each register keeps the low bits of the written data.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_START_DELIM: cfg_next.start_delimiter  = cfg_data[7:0];
                CFG_FRAME_TYPE:  cfg_next.frame_type_code  = cfg_data[7:0];
                CFG_FRAME_IDENT: cfg_next.frame_ident      = cfg_data[7:0];
                CFG_DEST_ADDR:   cfg_next.dest_address     = cfg_data[63:0];
                CFG_NET_ADDR:    cfg_next.network_address  = cfg_data[15:0];
                CFG_RADIUS:      cfg_next.broadcast_radius = cfg_data[7:0];
                CFG_OPTIONS:     cfg_next.option_bits      = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Register update with the documented reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delimiter  <= RST_START_DELIM;
            cfg_reg.frame_type_code  <= RST_FRAME_TYPE;
            cfg_reg.frame_ident      <= RST_FRAME_IDENT;
            cfg_reg.dest_address     <= RST_DEST_ADDR;
            cfg_reg.network_address  <= RST_NET_ADDR;
            cfg_reg.broadcast_radius <= RST_RADIUS;
            cfg_reg.option_bits      <= RST_OPTIONS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/atfb_checker.sv
// Port-level checks for the API transmit frame builder, bound to its top level.
// Depends on atfb_pkg and on api_transmit_frame_builder.
`timescale 1ns / 1ps

module atfb_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_ready,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  atfb_pkg::out_item_t   m_data,
    input  logic                  cfg_ready
);
    import atfb_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The checksum always closes the bytes of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> m_data.run_last)
        else $error("checksum without run_last");

    // Reset leaves no result pending and the input open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // The configuration port never back-pressures.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind api_transmit_frame_builder atfb_checker u_atfb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
